// ===== rtl/core/hsl2rgb_pkg.sv =====
package hsl2rgb_pkg;

   localparam int FIELD_W = 16;
   localparam int HUE_BITS_DEF = 16;
   localparam int LEVEL_FRAC_BITS_DEF = 15;

   typedef logic [FIELD_W-1:0] field_type;

endpackage

// ===== rtl/core/hsl2rgb_if.sv =====
interface hsl2rgb_req_if;
   import hsl2rgb_pkg::*;

   logic      valid;
   logic      ready;
   field_type hue;
   field_type sat;
   field_type light;

   modport source (output valid, hue, sat, light, input ready);
   modport sink (input valid, hue, sat, light, output ready);
endinterface

interface hsl2rgb_rsp_if;
   import hsl2rgb_pkg::*;

   logic      valid;
   logic      ready;
   field_type red;
   field_type green;
   field_type blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/core/hsl_to_rgb_converter.sv =====
// Channel   Direction   Beat fields
// req_if    in          hue, sat, light
// rsp_if    out         red, green, blue
//
// One beat is accepted per cycle while req_if.ready is high. A result is valid
// in the output register and leaves at an edge with rsp_if.ready high.
// The six register stages are level clamp and hue offsets, hue decode with the
// level multiply, upper level, lower level and span, ramp multiply, and the
// final add into the output register.
// Reset clears the valid bit of every stage; the data registers are not reset.
// A stage holds its beat only while the stage after it is full and held, so
// bubbles close up and input is taken while a finished result still waits.
module hsl_to_rgb_converter #(
   parameter int HUE_BITS        = hsl2rgb_pkg::HUE_BITS_DEF,
   parameter int LEVEL_FRAC_BITS = hsl2rgb_pkg::LEVEL_FRAC_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   hsl2rgb_req_if.sink   req_if,
   hsl2rgb_rsp_if.source rsp_if
);
   import hsl2rgb_pkg::*;

   localparam int HB     = HUE_BITS;
   localparam int LW     = LEVEL_FRAC_BITS + 1;
   localparam int CW     = (LW > FIELD_W) ? LW : FIELD_W;
   localparam int PW     = 2 * LW + 1;
   localparam int RPW    = LW + HB + 1;
   localparam int STAGES = 6;
   localparam int THIRD  = ((1 << HB) + 1) / 3;

   localparam logic [LW-1:0]   LEVEL_ONE  = LW'(1) << LEVEL_FRAC_BITS;
   localparam logic [LW-1:0]   LEVEL_HALF = LEVEL_ONE >> 1;
   localparam logic [HB+2:0]   TURN_X     = (HB+3)'(1) << HB;
   localparam logic [HB-1:0]   THIRD_TURN = HB'(THIRD);

   typedef enum logic [1:0] {SEG_RISE, SEG_HIGH, SEG_FALL, SEG_LOW} seg_type;

   typedef struct packed {
      seg_type       seg;
      logic [HB:0]   factor;
   } ramp_type;

   typedef struct packed {
      logic [2:0][HB-1:0] hue;
      logic [LW-1:0]      s;
      logic [LW-1:0]      l;
   } st1_type;

   typedef struct packed {
      ramp_type [2:0] ramp;
      logic           half;
      logic [LW-1:0]  s;
      logic [LW-1:0]  l;
      logic [PW-1:0]  prod;
   } st2_type;

   typedef struct packed {
      ramp_type [2:0] ramp;
      logic [LW-1:0]  l;
      logic [LW-1:0]  m2;
   } st3_type;

   typedef struct packed {
      ramp_type [2:0] ramp;
      logic [LW-1:0]  m1;
      logic [LW-1:0]  m2;
      logic [LW-1:0]  span;
   } st4_type;

   typedef struct packed {
      ramp_type [2:0]      ramp;
      logic [LW-1:0]       m1;
      logic [LW-1:0]       m2;
      logic [2:0][RPW-1:0] prod;
   } st5_type;

   typedef struct packed {
      field_type red;
      field_type green;
      field_type blue;
   } st6_type;

   function automatic ramp_type decode_hue(input logic [HB-1:0] h);
      logic [HB+2:0] h1;
      logic [HB+2:0] h2;
      logic [HB+2:0] h3;
      logic [HB+2:0] h6;
      ramp_type      r;
      h1 = (HB+3)'(h);
      h2 = h1 << 1;
      h3 = h1 + h2;
      h6 = h3 << 1;
      r.factor = (HB+1)'(h6);
      if (h6 < TURN_X) begin
         r.seg = SEG_RISE;
      end else if (h2 < TURN_X) begin
         r.seg = SEG_HIGH;
      end else if (h3 < (TURN_X << 1)) begin
         r.seg    = SEG_FALL;
         r.factor = (HB+1)'((TURN_X << 2) - h6);
      end else begin
         r.seg = SEG_LOW;
      end
      return r;
   endfunction

   function automatic logic [LW-1:0] apply_ramp(input ramp_type r,
                                                input logic [LW-1:0] lo,
                                                input logic [LW-1:0] hi,
                                                input logic [RPW-1:0] prod);
      logic [LW-1:0] rise;
      logic [LW-1:0] v;
      rise = LW'(prod >> HB) + lo;
      case (r.seg)
         SEG_RISE: v = rise;
         SEG_HIGH: v = hi;
         SEG_FALL: v = rise;
         default:  v = lo;
      endcase
      return v;
   endfunction

   logic [STAGES-1:0] vld_ff, vld_in, adv;

   st1_type st1_ff, st1_in;
   st2_type st2_ff, st2_in;
   st3_type st3_ff, st3_in;
   st4_type st4_ff, st4_in;
   st5_type st5_ff, st5_in;
   st6_type st6_ff, st6_in;

   logic [CW-1:0] sat_w, light_w;
   logic [HB-1:0] hue_g;
   logic [LW:0]   mul_b;
   logic [LW-1:0] prod_hi;
   logic [LW:0]   sum_ls;
   logic [LW:0]   two_l;
   logic [LW-1:0] m1;

   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || rsp_if.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? req_if.valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_if.ready = adv[0];

   always_comb begin
      sat_w        = CW'(req_if.sat);
      light_w      = CW'(req_if.light);
      hue_g        = HB'(req_if.hue);
      st1_in.hue[1] = hue_g;
      st1_in.hue[0] = hue_g + THIRD_TURN;
      st1_in.hue[2] = hue_g - THIRD_TURN;
      st1_in.s     = (sat_w > CW'(LEVEL_ONE)) ? LEVEL_ONE : LW'(sat_w);
      st1_in.l     = (light_w > CW'(LEVEL_ONE)) ? LEVEL_ONE : LW'(light_w);
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         st2_in.ramp[c] = decode_hue(st1_ff.hue[c]);
      end
      st2_in.half = (st1_ff.l <= LEVEL_HALF);
      st2_in.s    = st1_ff.s;
      st2_in.l    = st1_ff.l;
      mul_b       = st2_in.half ? ((LW+1)'(LEVEL_ONE) + (LW+1)'(st1_ff.s))
                                : (LW+1)'(st1_ff.s);
      st2_in.prod = PW'(st1_ff.l) * PW'(mul_b);
   end

   always_comb begin
      prod_hi     = LW'(st2_ff.prod >> LEVEL_FRAC_BITS);
      sum_ls      = (LW+1)'(st2_ff.l) + (LW+1)'(st2_ff.s) - (LW+1)'(prod_hi);
      st3_in.ramp = st2_ff.ramp;
      st3_in.l    = st2_ff.l;
      st3_in.m2   = st2_ff.half ? prod_hi : LW'(sum_ls);
   end

   always_comb begin
      two_l       = (LW+1)'(st3_ff.l) << 1;
      m1          = (two_l >= (LW+1)'(st3_ff.m2)) ?
                    LW'(two_l - (LW+1)'(st3_ff.m2)) : '0;
      st4_in.ramp = st3_ff.ramp;
      st4_in.m1   = m1;
      st4_in.m2   = st3_ff.m2;
      st4_in.span = (st3_ff.m2 >= m1) ? (st3_ff.m2 - m1) : '0;
   end

   always_comb begin
      st5_in.ramp = st4_ff.ramp;
      st5_in.m1   = st4_ff.m1;
      st5_in.m2   = st4_ff.m2;
      for (int c = 0; c < 3; c++) begin
         st5_in.prod[c] = RPW'(st4_ff.span) * RPW'(st4_ff.ramp[c].factor);
      end
   end

   always_comb begin
      st6_in.red   = FIELD_W'(apply_ramp(st5_ff.ramp[0], st5_ff.m1, st5_ff.m2,
                                         st5_ff.prod[0]));
      st6_in.green = FIELD_W'(apply_ramp(st5_ff.ramp[1], st5_ff.m1, st5_ff.m2,
                                         st5_ff.prod[1]));
      st6_in.blue  = FIELD_W'(apply_ramp(st5_ff.ramp[2], st5_ff.m1, st5_ff.m2,
                                         st5_ff.prod[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         st1_ff <= st1_in;
      end
      if (adv[1]) begin
         st2_ff <= st2_in;
      end
      if (adv[2]) begin
         st3_ff <= st3_in;
      end
      if (adv[3]) begin
         st4_ff <= st4_in;
      end
      if (adv[4]) begin
         st5_ff <= st5_in;
      end
      if (adv[5]) begin
         st6_ff <= st6_in;
      end
   end

   assign rsp_if.valid = vld_ff[STAGES-1];
   assign rsp_if.red   = st6_ff.red;
   assign rsp_if.green = st6_ff.green;
   assign rsp_if.blue  = st6_ff.blue;

endmodule

// ===== tb/hsl_to_rgb_converter_test.sv =====
`timescale 1ns / 1ps

module hsl_to_rgb_converter_test;
   import hsl2rgb_pkg::*;

   localparam int HUE_W = HUE_BITS_DEF;
   localparam int FRAC_W = LEVEL_FRAC_BITS_DEF;
   localparam int DIRECTED_COUNT = 21;
   localparam int RANDOM_COUNT = 900;
   localparam int SETTLE_CYCLES = 20;

   typedef bit [47:0] wide_type;

   localparam wide_type FULL_TURN = wide_type'(1) << HUE_W;
   localparam wide_type HUE_MASK = FULL_TURN - 1;
   localparam wide_type TURN_THIRD = (FULL_TURN + 1) / 3;
   localparam wide_type UNIT_LEVEL = wide_type'(1) << FRAC_W;
   localparam wide_type HALF_LEVEL = UNIT_LEVEL >> 1;

   typedef struct packed {
      field_type red;
      field_type green;
      field_type blue;
   } color_type;

   class color_scoreboard;
      color_type expected_colors[$];
      int unsigned pixels;
      int unsigned grey_pixels;
      int unsigned clamped_pixels;
      int unsigned checked_colors;
      int unsigned failures;

      function wide_type clamp_level(input field_type v);
         return (wide_type'(v) > UNIT_LEVEL) ? UNIT_LEVEL : wide_type'(v);
      endfunction

      function wide_type ramp_level(input wide_type lo, input wide_type hi,
                                    input wide_type h);
         wide_type span;
         span = (hi >= lo) ? hi - lo : 0;
         if (6 * h < FULL_TURN)
            return lo + ((span * (6 * h)) >> HUE_W);
         if (2 * h < FULL_TURN)
            return hi;
         if (3 * h < 2 * FULL_TURN)
            return lo + ((span * (4 * FULL_TURN - 6 * h)) >> HUE_W);
         return lo;
      endfunction

      function color_type convert_pixel(input field_type hue, input field_type sat,
                                        input field_type light);
         wide_type h;
         wide_type s;
         wide_type l;
         wide_type upper;
         wide_type lower;
         color_type c;
         h = wide_type'(hue) & HUE_MASK;
         s = clamp_level(sat);
         l = clamp_level(light);
         if (s == 0) begin
            c.red = field_type'(l);
            c.green = field_type'(l);
            c.blue = field_type'(l);
         end else begin
            if (l <= HALF_LEVEL)
               upper = (l * (UNIT_LEVEL + s)) >> FRAC_W;
            else
               upper = l + s - ((l * s) >> FRAC_W);
            lower = (2 * l >= upper) ? 2 * l - upper : 0;
            c.red = field_type'(ramp_level(lower, upper, (h + TURN_THIRD) & HUE_MASK));
            c.green = field_type'(ramp_level(lower, upper, h));
            c.blue = field_type'(ramp_level(lower, upper,
                                            (h + FULL_TURN - TURN_THIRD) & HUE_MASK));
         end
         return c;
      endfunction

      function void note_pixel(input field_type hue, input field_type sat,
                               input field_type light);
         pixels++;
         if (sat == 0)
            grey_pixels++;
         if (wide_type'(sat) > UNIT_LEVEL || wide_type'(light) > UNIT_LEVEL)
            clamped_pixels++;
         expected_colors.push_back(convert_pixel(hue, sat, light));
      endfunction

      function void check_color(input field_type red, input field_type green,
                                input field_type blue);
         color_type want;
         if (expected_colors.size() == 0) begin
            $error("Unexpected result beat: red %0d green %0d blue %0d", red, green, blue);
            failures++;
            return;
         end
         want = expected_colors.pop_front();
         checked_colors++;
         if (red !== want.red) begin
            $error("Mismatch on red: expected %0d, actual %0d", want.red, red);
            failures++;
         end
         if (green !== want.green) begin
            $error("Mismatch on green: expected %0d, actual %0d", want.green, green);
            failures++;
         end
         if (blue !== want.blue) begin
            $error("Mismatch on blue: expected %0d, actual %0d", want.blue, blue);
            failures++;
         end
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   hsl2rgb_req_if req ();
   hsl2rgb_rsp_if rsp ();

   color_scoreboard sb = new();

   hsl_to_rgb_converter DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_pixel(input field_type h, input field_type s, input field_type l);
      req.valid <= 1'b1;
      req.hue <= h;
      req.sat <= s;
      req.light <= l;
      do @(posedge clock); while (!req.ready);
      sb.note_pixel(h, s, l);
   endtask

   task automatic pause_sender(input int cycles);
      req.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic field_type pick_edge_level();
      field_type edges[7] = '{16'd0, 16'd1, 16'd16383, 16'd16384, 16'd16385,
                              16'd32767, 16'd32768};
      return edges[$urandom_range(0, 6)];
   endfunction

   function automatic field_type pick_edge_hue();
      field_type edges[10] = '{16'd0, 16'd10922, 16'd10923, 16'd21845, 16'd32767,
                               16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd65535};
      return edges[$urandom_range(0, 9)] + field_type'($urandom_range(0, 4)) - 16'd2;
   endfunction

   initial begin
      static field_type directed_set[DIRECTED_COUNT][3] = '{
         '{16'd0, 16'd32768, 16'd16384},
         '{16'd65535, 16'd32768, 16'd16384},
         '{16'd10922, 16'd32768, 16'd16384},
         '{16'd10923, 16'd32768, 16'd16384},
         '{16'd32767, 16'd32768, 16'd16384},
         '{16'd32768, 16'd32768, 16'd16384},
         '{16'd43690, 16'd32768, 16'd16384},
         '{16'd43691, 16'd32768, 16'd16384},
         '{16'd21845, 16'd20000, 16'd12000},
         '{16'd12345, 16'd0, 16'd20000},
         '{16'd0, 16'd0, 16'd65535},
         '{16'd40000, 16'd32768, 16'd0},
         '{16'd40000, 16'd32768, 16'd32768},
         '{16'd5000, 16'd65535, 16'd10000},
         '{16'd5000, 16'd20000, 16'd65535},
         '{16'd30000, 16'd20000, 16'd16384},
         '{16'd30000, 16'd20000, 16'd16385},
         '{16'd65535, 16'd65535, 16'd65535},
         '{16'hAAAA, 16'h5555, 16'h5555},
         '{16'h5555, 16'hAAAA, 16'hAAAA},
         '{16'd1, 16'd1, 16'd1}
      };
      field_type h;
      field_type s;
      field_type l;
      int burst_left;
      int gap;

      reset <= 1'b1;
      req.valid <= 1'b0;
      req.hue <= '0;
      req.sat <= '0;
      req.light <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_pixel(directed_set[i][0], directed_set[i][1], directed_set[i][2]);
      pause_sender(3);

      burst_left = $urandom_range(1, 30);
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         h = field_type'($urandom_range(0, 65535));
         s = field_type'($urandom_range(0, 32768));
         l = field_type'($urandom_range(0, 32768));
         case ($urandom_range(0, 9))
            6: s = '0;
            7: begin
               s = field_type'($urandom_range(0, 65535));
               l = field_type'($urandom_range(0, 65535));
            end
            8: begin
               h = pick_edge_hue();
               s = pick_edge_level();
               l = pick_edge_level();
            end
            9: h = pick_edge_hue();
            default: ;
         endcase
         send_pixel(h, s, l);

         if (i == RANDOM_COUNT / 2) begin
            wait_for_results();
         end else if (--burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if ($urandom_range(0, 15) == 0)
               gap = 40;
            if (gap > 0)
               pause_sender(gap);
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d pixels: %0d grey, %0d with a level above one.",
               sb.pixels, sb.grey_pixels, sb.clamped_pixels);
      $display("Checked %0d result beats, %0d field mismatches, %0d still outstanding.",
               sb.checked_colors, sb.failures, sb.pending());
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      int unsigned tick;
      tick = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready)
            sb.check_color(rsp.red, rsp.green, rsp.blue);
         tick++;
         case ((tick / 150) % 4)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 1) == 1);
            2: rsp.ready <= ($urandom_range(0, 4) == 0);
            default: rsp.ready <= tick[0];
         endcase
      end
   end

endmodule

// ===== sim.f =====
rtl/core/hsl2rgb_pkg.sv
rtl/core/hsl2rgb_if.sv
rtl/core/hsl_to_rgb_converter.sv
tb/hsl_to_rgb_converter_test.sv
